// ----- rtl/u8s_pkg.sv -----
// shared types and constants of the utf-8 sanitizer
`timescale 1ns / 1ps

package u8s_pkg;

    // replacement character '?'
    localparam logic [7:0] REPL_BYTE = 8'h3F;

    // bundle queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // most bytes one input beat can release
    localparam int MAX_OUT = 4;
    localparam int OCNT_W  = $clog2(MAX_OUT + 1);
    localparam int OIDX_W  = $clog2(MAX_OUT);

    typedef enum logic [1:0] {
        CLS_ASCII = 2'd0,
        CLS_CONT  = 2'd1,
        CLS_LEAD  = 2'd2,
        CLS_BAD   = 2'd3
    } byte_class_t;

    typedef struct packed {
        byte_class_t kind;
        logic [1:0]  need;   // continuations a lead byte needs
    } class_info_t;

    // all output bytes released by one input beat
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] data;
        logic [OCNT_W-1:0]       count;
        logic                    last;
    } bundle_t;

    function automatic class_info_t classify(input logic [7:0] b);
        class_info_t ci;
        ci.kind = CLS_BAD;
        ci.need = 2'd0;
        case (b) inside
            8'b0???_????: ci.kind = CLS_ASCII;
            8'b10??_????: ci.kind = CLS_CONT;
            8'b110?_????:
            begin
                ci.kind = CLS_LEAD;
                ci.need = 2'd1;
            end
            8'b1110_????:
            begin
                ci.kind = CLS_LEAD;
                ci.need = 2'd2;
            end
            8'b1111_0???:
            begin
                ci.kind = CLS_LEAD;
                ci.need = 2'd3;
            end
            default: ci.kind = CLS_BAD;
        endcase
        return ci;
    endfunction

endpackage

// ----- rtl/u8s_front.sv -----
// front end: classifies input bytes, tracks pending sequences, builds bundles
`timescale 1ns / 1ps

module u8s_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              is_last,
    input  logic              q_ready,
    output logic              push,
    output u8s_pkg::bundle_t  bundle
);

    logic [7:0]           held_reg [3];
    logic [1:0]           hc_reg;
    logic [1:0]           hc_next;
    logic [1:0]           ec_reg;
    logic [1:0]           ec_next;
    u8s_pkg::class_info_t cls;
    logic                 accept;
    logic                 held_active;
    logic                 is_cont;
    logic                 complete;
    logic                 store;
    logic [1:0]           pre_cnt;
    logic                 has_x;
    logic [7:0]           x_byte;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign push     = accept && (bundle.count != '0);

    always_comb
    begin
        cls         = u8s_pkg::classify(in_byte);
        held_active = (hc_reg != 2'd0) && (ec_reg != 2'd0);
        is_cont     = (cls.kind == u8s_pkg::CLS_CONT);
        complete    = held_active && is_cont && (hc_reg >= ec_reg);
        store       = held_active && is_cont && !complete;
        pre_cnt     = (held_active && !is_cont) ? hc_reg : 2'd0;
        // fresh byte: lead bytes stay held unless the string ends here
        has_x       = (cls.kind != u8s_pkg::CLS_LEAD) || is_last;
        x_byte      = (cls.kind == u8s_pkg::CLS_ASCII) ? in_byte : u8s_pkg::REPL_BYTE;

        bundle.last = is_last;
        hc_next     = 2'd0;
        ec_next     = 2'd0;
        if (complete)
        begin
            bundle.count = u8s_pkg::OCNT_W'(hc_reg) + u8s_pkg::OCNT_W'(1);
            for (int i = 0; i < u8s_pkg::MAX_OUT; i++)
            begin
                if (i < 3 && i < int'(hc_reg))
                    bundle.data[i] = held_reg[i < 3 ? i : 0];
                else
                    bundle.data[i] = in_byte;
            end
        end
        else if (store)
        begin
            bundle.count = is_last ? u8s_pkg::OCNT_W'(hc_reg) + u8s_pkg::OCNT_W'(1) : '0;
            for (int i = 0; i < u8s_pkg::MAX_OUT; i++)
                bundle.data[i] = u8s_pkg::REPL_BYTE;
            if (!is_last)
            begin
                hc_next = hc_reg + 2'd1;
                ec_next = ec_reg;
            end
        end
        else
        begin
            bundle.count = u8s_pkg::OCNT_W'(pre_cnt) + u8s_pkg::OCNT_W'(has_x);
            for (int i = 0; i < u8s_pkg::MAX_OUT; i++)
                bundle.data[i] = (i == int'(pre_cnt)) ? x_byte : u8s_pkg::REPL_BYTE;
            if (cls.kind == u8s_pkg::CLS_LEAD && !is_last)
            begin
                hc_next = 2'd1;
                ec_next = cls.need;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg <= 2'd0;
            ec_reg <= 2'd0;
        end
        else if (accept)
        begin
            hc_reg <= hc_next;
            ec_reg <= ec_next;
        end
    end

    // held bytes carry no reset
    always_ff @(posedge clk)
    begin
        if (accept && store && hc_reg < 2'd3)
            held_reg[hc_reg] <= in_byte;
        else if (accept && !complete && !store && cls.kind == u8s_pkg::CLS_LEAD)
            held_reg[0] <= in_byte;
    end

    a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_last |=> hc_reg == 2'd0 && ec_reg == 2'd0)
        else $error("pending sequence survived end of string");

    a_hold_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        hc_reg <= ec_reg)
        else $error("more bytes held than the lead needs");

endmodule

// ----- rtl/u8s_queue.sv -----
// short bundle queue between front and back
`timescale 1ns / 1ps

module u8s_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  u8s_pkg::bundle_t wr_bundle,
    output logic             not_full,
    input  logic             pop,
    output logic             not_empty,
    output u8s_pkg::bundle_t rd_bundle
);

    u8s_pkg::bundle_t              mem_reg [u8s_pkg::QDEPTH];
    u8s_pkg::bundle_t              rd_reg;
    logic [u8s_pkg::QPTR_W-1:0]    wp_reg;
    logic [u8s_pkg::QPTR_W-1:0]    wp_next;
    logic [u8s_pkg::QPTR_W-1:0]    rp_reg;
    logic [u8s_pkg::QPTR_W-1:0]    rp_next;
    logic [u8s_pkg::QCNT_W-1:0]    cnt_reg;
    logic [u8s_pkg::QCNT_W-1:0]    cnt_next;
    logic                          do_push;
    logic                          do_pop;

    assign not_full  = (cnt_reg != u8s_pkg::QCNT_W'(u8s_pkg::QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign rd_bundle = rd_reg;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_push)
            wp_next = (wp_reg == u8s_pkg::QPTR_W'(u8s_pkg::QDEPTH - 1)) ? '0
                                                                        : wp_reg + 1'b1;
        if (do_pop)
            rp_next = (rp_reg == u8s_pkg::QPTR_W'(u8s_pkg::QDEPTH - 1)) ? '0
                                                                        : rp_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wp_reg] <= wr_bundle;
    end

    // head entry registered, with write-through when the new head is written now
    always_ff @(posedge clk)
    begin
        if (do_push && wp_reg == rp_next)
            rd_reg <= wr_bundle;
        else
            rd_reg <= mem_reg[rp_next];
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> not_full)
        else $error("bundle pushed into a full queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        !push && !pop |=> $stable(cnt_reg))
        else $error("queue fill level moved without push or pop");

endmodule

// ----- rtl/u8s_back.sv -----
// back end: plays out one bundle byte per beat
`timescale 1ns / 1ps

module u8s_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  u8s_pkg::bundle_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic             out_last
);

    logic [u8s_pkg::OIDX_W-1:0] idx_reg;
    logic [u8s_pkg::OIDX_W-1:0] idx_next;
    logic                       at_end;
    logic                       beat;

    assign out_valid = q_not_empty;
    assign at_end    = (u8s_pkg::OCNT_W'(idx_reg) + u8s_pkg::OCNT_W'(1)) == head.count;
    assign out_byte  = head.data[idx_reg];
    assign out_last  = head.last && at_end;
    assign beat      = out_valid && out_ready;
    assign pop       = beat && at_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (beat)
            idx_next = at_end ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

    a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> u8s_pkg::OCNT_W'(idx_reg) < head.count)
        else $error("byte index past end of bundle");

endmodule

// ----- rtl/utf8_sanitizer_core.sv -----
// top level of the utf-8 sanitizer
`timescale 1ns / 1ps

// utf8_sanitizer_core cleans a byte stream so it holds only well-formed utf-8
// sequences judged by bit pattern. one byte beat enters per cycle; ascii passes
// straight through, a lead byte is held with its continuations until the
// sequence completes and is then released whole, and a broken sequence, a
// stray continuation or a 0xF8+ byte turns into '?' (0x3F) bytes. out_last
// marks the final output byte of a string. the front end classifies each byte
// in the cycle it is accepted and pushes the bytes it releases (up to four) as
// one bundle into a four-deep queue; the back end plays the bundle out one byte
// per cycle while out_ready holds. input rate is one byte per cycle while the
// queue has room; output is one byte per cycle while out_ready holds, so a
// long run of multi-byte releases is paced by the output side at one output
// byte per cycle. a bundle is registered in the queue before it is played out.

module utf8_sanitizer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    // front to queue
    logic             push;
    logic             q_not_full;
    u8s_pkg::bundle_t push_bundle;

    // queue to back
    logic             pop;
    logic             q_not_empty;
    u8s_pkg::bundle_t head_bundle;

    // classification and pending-sequence tracking
    u8s_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .is_last  (is_last),
        .q_ready  (q_not_full),
        .push     (push),
        .bundle   (push_bundle)
    );

    // decouples the two sides so each can stall alone
    u8s_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_bundle (push_bundle),
        .not_full  (q_not_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .rd_bundle (head_bundle)
    );

    // serializes each bundle onto the output channel
    u8s_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head        (head_bundle),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .out_last    (out_last)
    );

endmodule

// ----- tb/utf8_sanitizer_checker.sv -----
// checker for the utf-8 sanitizer: predicts the cleaned byte stream and compares it
`timescale 1ns / 1ps

module utf8_sanitizer_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       is_last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       out_last,
    output int         fail_count,
    output int         pending,
    output int         str_count,
    output int         in_beats,
    output int         out_beats,
    output int         repl_beats
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_beat_t;

    // cleaned bytes still owed by the block, oldest first
    text_beat_t sanitized_q[$];

    // partial multi-byte sequence: lead plus continuations so far
    logic [7:0] held_seq [3];
    logic [1:0] held_cnt;
    logic [1:0] need_cnt;

    function automatic u8s_pkg::byte_class_t kind_of(input logic [7:0] b,
                                                     output logic [1:0] need);
        need = 2'd0;
        if (!b[7])
            return u8s_pkg::CLS_ASCII;
        if (b[7:6] == 2'b10)
            return u8s_pkg::CLS_CONT;
        if (b[7:5] == 3'b110)
        begin
            need = 2'd1;
            return u8s_pkg::CLS_LEAD;
        end
        if (b[7:4] == 4'b1110)
        begin
            need = 2'd2;
            return u8s_pkg::CLS_LEAD;
        end
        if (b[7:3] == 5'b11110)
        begin
            need = 2'd3;
            return u8s_pkg::CLS_LEAD;
        end
        return u8s_pkg::CLS_BAD;
    endfunction

    task automatic push_text(input logic [7:0] b);
        sanitized_q.push_back('{data: b, last: 1'b0});
    endtask

    task automatic push_repl();
        push_text(u8s_pkg::REPL_BYTE);
        repl_beats++;
    endtask

    // every held byte turns into '?'
    task automatic drop_held();
        repeat (held_cnt) push_repl();
        held_cnt = 2'd0;
        need_cnt = 2'd0;
    endtask

    task automatic open_fresh(input logic [7:0] b);
        u8s_pkg::byte_class_t k;
        logic [1:0]           need;
        k = kind_of(b, need);
        case (k)
            u8s_pkg::CLS_ASCII: push_text(b);
            u8s_pkg::CLS_LEAD:
            begin
                held_seq[0] = b;
                held_cnt    = 2'd1;
                need_cnt    = need;
            end
            default: push_repl();
        endcase
    endtask

    task automatic sanitize_beat(input logic [7:0] b, input logic l);
        int                   base_n;
        u8s_pkg::byte_class_t k;
        logic [1:0]           need;
        base_n = sanitized_q.size();
        k = kind_of(b, need);
        if (need_cnt != 2'd0 && held_cnt != 2'd0)
        begin
            if (k == u8s_pkg::CLS_CONT)
            begin
                if (held_cnt >= need_cnt)
                begin
                    for (int i = 0; i < held_cnt; i++)
                        push_text(held_seq[i]);
                    push_text(b);
                    held_cnt = 2'd0;
                    need_cnt = 2'd0;
                end
                else
                begin
                    held_seq[held_cnt] = b;
                    held_cnt++;
                end
            end
            else
            begin
                drop_held();
                open_fresh(b);
            end
        end
        else
        begin
            held_cnt = 2'd0;
            need_cnt = 2'd0;
            open_fresh(b);
        end
        if (l)
        begin
            drop_held();
            if (sanitized_q.size() > base_n)
                sanitized_q[sanitized_q.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        text_beat_t want;
        if (!rst_n)
        begin
            sanitized_q.delete();
            held_cnt   = 2'd0;
            need_cnt   = 2'd0;
            fail_count = 0;
            str_count  = 0;
            in_beats   = 0;
            out_beats  = 0;
            repl_beats = 0;
            pending   <= 0;
        end
        else
        begin
            // output side first: a beat leaving now comes from earlier inputs
            if (out_valid && out_ready)
            begin
                out_beats++;
                if (sanitized_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t unexpected output %02h last %b, nothing pending",
                                 $realtime, out_byte, out_last);
                    fail_count++;
                end
                else
                begin
                    want = sanitized_q.pop_front();
                    if (want.data !== out_byte || want.last !== out_last)
                    begin
                        if (fail_count < 10)
                            $display("%0t mismatch: expected %02h last %b, got %02h last %b",
                                     $realtime, want.data, want.last, out_byte, out_last);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                in_beats++;
                if (is_last)
                    str_count++;
                sanitize_beat(in_byte, is_last);
            end
            pending <= sanitized_q.size();
        end
    end

endmodule

// ----- tb/tb_utf8_sanitizer_core.sv -----
// testbench top of the utf-8 sanitizer: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_utf8_sanitizer_core;

    // cycles with no beat on either side before the run is declared hung
    localparam int QUIET_LIMIT  = 4000;
    // random input bytes after the directed strings
    localparam int RANDOM_BYTES = 450;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       is_last;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;

    int fail_count;
    int pending;
    int str_count;
    int in_beats;
    int out_beats;
    int repl_beats;

    // sender burst bookkeeping
    int burst_left  = 0;
    int drain_waits = 0;
    int rand_sent   = 0;

    // receiver stall pattern state
    int stall_mode = 0;
    int stall_left = 0;

    int quiet_cycles = 0;

    // bytes of the string being built, sent with is_last on the final one
    logic [7:0] text_q[$];

    always #6 clk = ~clk;

    utf8_sanitizer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    utf8_sanitizer_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .fail_count (fail_count),
        .pending    (pending),
        .str_count  (str_count),
        .in_beats   (in_beats),
        .out_beats  (out_beats),
        .repl_beats (repl_beats)
    );

    // receiver: switches between always ready, coin flip, one in four and
    // mostly stalled, each mode held for a random stretch of cycles
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 120);
            end
            else
                stall_left--;
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= (stall_left % 4 == 0);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // watchdog: a correct block never sits this long with no beat moving
    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_utf8_sanitizer_core NOT OK");
                $finish;
            end
        end
        else
            quiet_cycles = 0;
    end

    // one input beat; called at a falling edge and returns at a falling edge.
    // a new burst may open with a gap of idle cycles, or run straight on
    task automatic send_beat(input logic [7:0] b, input logic l);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        is_last  <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_beat(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    // hold the sender off until every owed output byte has left
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        drain_waits++;
    endtask

    // one piece of a random string: mostly whole characters, some noise
    task automatic append_unit();
        int pick;
        int len;
        int conts;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            text_q.push_back(8'($urandom_range(1, 127)));
        else if (pick < 78)
        begin
            // multi-byte sequence, whole up to 70, cut short above
            len = $urandom_range(2, 4);
            case (len)
                2:       text_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                3:       text_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                default: text_q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
            endcase
            conts = (pick < 70) ? len - 1 : $urandom_range(0, len - 2);
            repeat (conts) text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
        else if (pick < 84)
            text_q.push_back(8'h80 | 8'($urandom_range(0, 63)));   // stray continuation
        else if (pick < 90)
            text_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));   // never valid in utf-8
        else
            text_q.push_back(8'($urandom_range(1, 255)));
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_byte  = 8'h01;
        is_last  = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ascii extremes, last on a plain byte
        text_q = '{8'h01, 8'h7F};
        send_text();
        // whole 2, 3 and 4 byte sequences, last on the completing beat
        text_q = '{8'hC2, 8'h80, 8'hE0, 8'hBF, 8'h80, 8'hF0, 8'h90, 8'h80, 8'hBF};
        send_text();
        // stray continuations and bytes from 0xF8 up
        text_q = '{8'h80, 8'hBF, 8'hF8, 8'hFF};
        send_text();
        // sequence broken by ascii, then by another lead, then string ends on a lead
        text_q = '{8'hE2, 8'h82, 8'h41, 8'hF7, 8'hC0, 8'hDF};
        send_text();
        // string ends with three bytes held
        text_q = '{8'hF0, 8'h80, 8'h80};
        send_text();
        wait_drained();

        // random strings of one to ten pieces
        while (rand_sent < RANDOM_BYTES)
        begin
            repeat ($urandom_range(1, 10)) append_unit();
            rand_sent += text_q.size();
            send_text();
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end

        // drain, then give the block time to show any stray extra output
        wait_drained();
        repeat (8) @(posedge clk);

        $display("covered %0d strings, %0d bytes in, %0d bytes out, %0d replaced by '?'",
                 str_count, in_beats, out_beats, repl_beats);
        $display("directed edge bytes plus random text, %0d full drain pauses", drain_waits);
        if (fail_count == 0)
            $display("tb_utf8_sanitizer_core OK");
        else
            $display("tb_utf8_sanitizer_core NOT OK");
        $finish;
    end

endmodule
